### sv/apdf_pkg.sv
// Package for the all-pass delay filter: widths, register indexes,
// controller states, datapath command struct and the saturation helper.
// Depends on nothing; every other file of the block uses it.
package apdf_pkg;

  localparam int DEPTH_DEFAULT = 65536;

  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 16;
  localparam int DELAY_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;

  // Q1.15 unity, also the largest mix level that means anything.
  localparam logic [16:0] UNITY = 17'd32768;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_LEVEL     = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_FB,
    S_WRITE
  } state_t;

  // Commands from the controller to the datapath, one per step.
  typedef struct packed {
    logic load;   // item accepted: capture sample, first product, issue read
    logic sum;    // form v from the product and the delayed entry, and the dry product
    logic fb;     // form the feedback and wet products
    logic write;  // store the new entry and register the result
  } cmd_t;

  localparam logic signed [26:0] SAT_MAX = 27'sd8388607;
  localparam logic signed [26:0] SAT_MIN = -27'sd8388608;

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [26:0] a);
    logic signed [SAMPLE_W-1:0] r;
    if (a > SAT_MAX) begin
      r = SAT_MAX[SAMPLE_W-1:0];
    end else if (a < SAT_MIN) begin
      r = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      r = a[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

### sv/apdf_ctrl.sv
// Controller of the all-pass delay filter: sequences one item through
// the datapath and owns the input ready and result valid. Uses apdf_pkg.
module apdf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output apdf_pkg::cmd_t cmd
);

  apdf_pkg::state_t state;
  apdf_pkg::state_t state_next;
  logic out_valid_next;

  // The result may be written once the output register is empty or
  // being emptied in this cycle.
  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      apdf_pkg::S_IDLE: begin
        if (in_valid) state_next = apdf_pkg::S_SUM;
      end
      apdf_pkg::S_SUM: begin
        state_next = apdf_pkg::S_FB;
      end
      apdf_pkg::S_FB: begin
        state_next = apdf_pkg::S_WRITE;
      end
      apdf_pkg::S_WRITE: begin
        if (out_free) state_next = apdf_pkg::S_IDLE;
      end
      default: begin
        state_next = apdf_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state)
      apdf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      apdf_pkg::S_SUM: begin
        cmd.sum = 1'b1;
      end
      apdf_pkg::S_FB: begin
        cmd.fb = 1'b1;
      end
      apdf_pkg::S_WRITE: begin
        cmd.write = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign out_valid_next = cmd.write || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= apdf_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### sv/apdf_datapath.sv
// Datapath of the all-pass delay filter: configuration registers, delay
// memory with its pointers, multipliers and saturation. Uses apdf_pkg.
module apdf_datapath #(
  parameter int DEPTH = apdf_pkg::DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [apdf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [apdf_pkg::CFG_DAT_W-1:0]        cfg_data,
  input  apdf_pkg::cmd_t                        cmd,
  input  logic signed [apdf_pkg::SAMPLE_W-1:0]  sample_in,
  output logic signed [apdf_pkg::SAMPLE_W-1:0]  sample_out
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > apdf_pkg::DELAY_W) ? CW : apdf_pkg::DELAY_W;
  localparam int SW = CW + 1;

  // Configuration registers.
  logic [apdf_pkg::DELAY_W-1:0]       delay_length;
  logic signed [apdf_pkg::GAIN_W-1:0] feedback_gain;
  logic [apdf_pkg::GAIN_W-1:0]        mix_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length  <= '0;
      feedback_gain <= '0;
      mix_level     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        apdf_pkg::REG_DELAY_LENGTH:  delay_length  <= cfg_data[apdf_pkg::DELAY_W-1:0];
        apdf_pkg::REG_FEEDBACK_GAIN: feedback_gain <= cfg_data[apdf_pkg::GAIN_W-1:0];
        apdf_pkg::REG_MIX_LEVEL:     mix_level     <= cfg_data[apdf_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective delay, limited to the memory depth.
  logic [LW-1:0] dl_ext;
  logic [LW-1:0] eff_ext;
  logic [CW-1:0] eff;
  assign dl_ext  = LW'(delay_length);
  assign eff_ext = (dl_ext > LW'(DEPTH)) ? LW'(DEPTH) : dl_ext;
  assign eff     = eff_ext[CW-1:0];

  // Mix limited to unity; dry weight is unity minus mix.
  logic [16:0]        mix_c;
  logic signed [16:0] wet_w;
  logic signed [16:0] dry_w;
  assign mix_c = ({1'b0, mix_level} > apdf_pkg::UNITY) ? apdf_pkg::UNITY : {1'b0, mix_level};
  assign wet_w = $signed(mix_c);
  assign dry_w = $signed(apdf_pkg::UNITY - mix_c);

  // Pointers.
  logic [AW-1:0] wp;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_clamped;
  logic          hit_now;
  logic [SW-1:0] rd_sum;
  logic [SW-1:0] rd_wrap;
  logic [AW-1:0] rd_addr;

  assign fill_clamped = (fill > eff) ? eff : fill;
  assign hit_now      = (eff != '0) && (fill >= eff);
  // The oldest entry read on a full store sits eff slots behind wp.
  assign rd_sum  = SW'(wp) + SW'(DEPTH) - SW'(eff);
  assign rd_wrap = (rd_sum >= SW'(DEPTH)) ? (rd_sum - SW'(DEPTH)) : rd_sum;
  assign rd_addr = rd_wrap[AW-1:0];

  // Delay memory.
  logic signed [apdf_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic signed [apdf_pkg::SAMPLE_W-1:0] rdata;
  logic signed [apdf_pkg::SAMPLE_W-1:0] st;

  always_ff @(posedge clk) begin
    if (cmd.load) rdata <= mem[rd_addr];
    if (cmd.write && (eff != '0)) mem[wp] <= st;
  end

  // Arithmetic registers.
  logic signed [apdf_pkg::SAMPLE_W-1:0] x;
  logic                                 hit;
  logic signed [39:0]                   p_xg;
  logic signed [39:0]                   p_vg;
  logic signed [40:0]                   p_dry;
  logic signed [40:0]                   p_wet;
  logic signed [apdf_pkg::SAMPLE_W-1:0] v;

  logic signed [apdf_pkg::SAMPLE_W-1:0] rd_term;
  logic signed [26:0]                   v_sum;
  logic signed [26:0]                   st_sum;
  logic signed [26:0]                   y_sum;

  assign rd_term = hit ? rdata : '0;
  assign v_sum   = 27'($signed(p_xg[39:15])) + 27'(rd_term);
  assign st_sum  = 27'(x) - 27'($signed(p_vg[39:15]));
  assign y_sum   = 27'($signed(p_dry[40:15])) + 27'($signed(p_wet[40:15]));
  assign st      = apdf_pkg::sat24(st_sum);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x    <= sample_in;
      hit  <= hit_now;
      p_xg <= sample_in * feedback_gain;
    end
    if (cmd.sum) begin
      v     <= apdf_pkg::sat24(v_sum);
      p_dry <= x * dry_w;
    end
    if (cmd.fb) begin
      p_vg  <= v * feedback_gain;
      p_wet <= v * wet_w;
    end
    if (cmd.write) begin
      sample_out <= apdf_pkg::sat24(y_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else begin
      if (cmd.load) begin
        fill <= fill_clamped;
      end
      if (cmd.write && (eff != '0)) begin
        // A read on a full store drops one entry as the new one arrives.
        fill <= hit ? fill : fill + CW'(1);
        wp   <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
    end
  end

endmodule

### sv/allpass_delay_filter.sv
// Top level of the all-pass delay filter with dry/wet mix.
// Instantiates apdf_ctrl and apdf_datapath; uses apdf_pkg.
//
//   Channel  Signals                              Width  Moves
//   in       in_valid, in_ready, sample_in         24    one audio item
//   out      out_valid, out_ready, sample_out      24    one filtered item
//   cfg      cfg_valid, cfg_ready, cfg_index,      2/17  one register write
//            cfg_data
//
// Each item passes through these steps in order: the accept step (first
// multiply and delay memory read), the sum of v, the feedback and wet
// multiplies, and the store/output step, which loads the result register.
// The next item is taken only after the store/output step. The chain of
// dependent multiplies and the registered memory read set this sequence.
// Reset is synchronous and active high; it clears the configuration
// registers, the controller state, the write pointer and the fill count.
// The memory needs no clearing pass, since only entries counted by the fill
// count are ever read. A result that is not taken holds the last step, and
// with it the next item, until out_ready rises.
module allpass_delay_filter #(
  parameter int DEPTH = apdf_pkg::DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [apdf_pkg::SAMPLE_W-1:0]  sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [apdf_pkg::SAMPLE_W-1:0]  sample_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [apdf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [apdf_pkg::CFG_DAT_W-1:0]        cfg_data
);

  apdf_pkg::cmd_t cmd;
  logic           cfg_write;

  // Configuration writes are always taken; software writes only while idle, which the block itself does not enforce.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  apdf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  apdf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sample_in  (sample_in),
    .sample_out (sample_out)
  );

endmodule
